// File: rtl/clock_offset_estimator_assert.svh
// Assertion macros for the clock offset estimator.
// Used by the top level only; needs nothing else.
`ifndef CLOCK_OFFSET_ESTIMATOR_ASSERT_SVH
`define CLOCK_OFFSET_ESTIMATOR_ASSERT_SVH

// a implies b in the same cycle
`define COE_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the following cycle
`define COE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: rtl/coe_pkg.sv
// Shared types and constants of the clock offset estimator.
// Used by the controller, the datapath and the top level.
package coe_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

  localparam int TS_W       = 40;
  localparam int OFF_W      = 41;
  localparam int RTT_W      = 24;
  localparam int ALPHA_W    = 17;
  localparam int REQ_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int S1_W   = RTT_W + FILL_W;
  localparam int S2_W   = 2 * RTT_W + FILL_W;
  localparam int VAR_W  = 2 * RTT_W + 2 * FILL_W;
  localparam int SQ_W   = RTT_W + FILL_W;
  localparam int STEP_W = $clog2(SQ_W + 1);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_IS_SERVER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP1, S_PREP2, S_DIFF, S_MUL, S_COMMIT, S_SUM, S_SUMW,
    S_VAR1, S_VAR2, S_SQRT, S_DIVL, S_DIV, S_JIT, S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic prep1;
    logic prep2;
    logic diff;
    logic mul;
    logic commit;
    logic rd;
    logic var_mul;
    logic sqrt_load;
    logic sqrt_step;
    logic div_load;
    logic div_step;
    logic jit_write;
  } cmd_t;

  typedef struct packed {
    logic is_server;
    logic fill_nz;
    logic rd_last;
  } sts_t;

endpackage

// File: rtl/coe_ctrl.sv
// Sequencer of the clock offset estimator.
// Depends on coe_pkg; drives the datapath by cmd_t, reads sts_t.
module coe_ctrl
  import coe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  input  sts_t sts,
  output cmd_t cmd,
  output logic emit
);

  state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic step_last;

  assign step_last = (step == STEP_W'(SQ_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_VAR2 || state == S_DIVL) begin
        step <= '0;
      end else if (state == S_SQRT || state == S_DIV) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = sts.is_server ? S_DONE : S_PREP1;
      S_PREP1:  state_next = S_PREP2;
      S_PREP2:  state_next = S_DIFF;
      S_DIFF:   state_next = S_MUL;
      S_MUL:    state_next = S_COMMIT;
      S_COMMIT: state_next = sts.fill_nz ? S_SUM : S_DONE;
      S_SUM:    if (sts.rd_last) state_next = S_SUMW;
      S_SUMW:   state_next = S_VAR1;
      S_VAR1:   state_next = S_VAR2;
      S_VAR2:   state_next = S_SQRT;
      S_SQRT:   if (step_last) state_next = S_DIVL;
      S_DIVL:   state_next = S_DIV;
      S_DIV:    if (step_last) state_next = S_JIT;
      S_JIT:    state_next = S_DONE;
      S_DONE:   if (!out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    emit      = 1'b0;
    in_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_PREP1:  cmd.prep1     = 1'b1;
      S_PREP2:  cmd.prep2     = 1'b1;
      S_DIFF:   cmd.diff      = 1'b1;
      S_MUL:    cmd.mul       = 1'b1;
      S_COMMIT: cmd.commit    = 1'b1;
      S_SUM:    cmd.rd        = 1'b1;
      S_SUMW:   cmd           = '0;
      S_VAR1:   cmd.var_mul   = 1'b1;
      S_VAR2:   cmd.sqrt_load = 1'b1;
      S_SQRT:   cmd.sqrt_step = 1'b1;
      S_DIVL:   cmd.div_load  = 1'b1;
      S_DIV:    cmd.div_step  = 1'b1;
      S_JIT:    cmd.jit_write = 1'b1;
      S_DONE:   emit          = !out_busy;
      default:  cmd           = '0;
    endcase
  end

endmodule

// File: rtl/coe_dp.sv
// Datapath of the clock offset estimator: config registers, offset and
// round trip arithmetic, round trip window, square root and divide units.
// Depends on coe_pkg.
module coe_dp
  import coe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TS_W-1:0]       client_send_time,
  input  logic [TS_W-1:0]       server_receive_time,
  input  logic [TS_W-1:0]       server_send_time,
  input  logic [TS_W-1:0]       client_receive_time,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  res_accepted,
  output logic [OFF_W-1:0]      res_offset,
  output logic [RTT_W-1:0]      res_rtt,
  output logic [RTT_W-1:0]      res_jitter,
  output logic                  res_sync
);

  // configuration
  logic               is_server;
  logic [ALPHA_W-1:0] alpha;
  logic [REQ_W-1:0]   required;

  // latched item
  logic [TS_W-1:0] cs, sr, ss, cr;
  logic            srv;

  // per-item arithmetic
  logic [RTT_W-1:0]        rtt_r;
  logic signed [OFF_W-1:0] proc_r;
  logic signed [OFF_W-1:0] off_r;
  logic signed [OFF_W:0]   diff_off;
  logic signed [RTT_W:0]   diff_rtt;
  logic signed [OFF_W+ALPHA_W+1:0] prod_off;
  logic signed [RTT_W+ALPHA_W+1:0] prod_rtt;

  // state
  logic [RTT_W-1:0]  win_mem [WINDOW_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [WIN_AW-1:0] head;
  logic [OFF_W-1:0]  off_est;
  logic [RTT_W-1:0]  rtt_est;
  logic [RTT_W-1:0]  jit_est;
  logic [REQ_W-1:0]  count;
  logic              sync_flag;

  // window walk and statistics
  logic [WIN_AW-1:0] idx;
  logic [RTT_W-1:0]  mem_q;
  logic              rd_vld;
  logic [S1_W-1:0]   s1;
  logic [S2_W-1:0]   s2;
  logic [VAR_W-1:0]  ns2, s1sq, var_sh;
  logic [SQ_W+1:0]   rem;
  logic [SQ_W-1:0]   root;
  logic [SQ_W-1:0]   quo;
  logic [FILL_W-1:0] div_r;

  // combinational terms
  logic [RTT_W-1:0]        rtt_clamp;
  logic signed [OFF_W:0]   half, half_d;
  logic signed [OFF_W+2:0] off_w;
  logic [OFF_W-1:0]        off_sat;
  logic [ALPHA_W-1:0]      alpha_c;
  logic signed [OFF_W+ALPHA_W+1:0] pq_off;
  logic signed [RTT_W+ALPHA_W+1:0] pq_rtt;
  logic [REQ_W-1:0]  count_next;
  logic [SQ_W+1:0]   rem_sh, trial;
  logic [FILL_W:0]   div_sh;
  logic [VAR_W-1:0]  fill_x;
  logic [2*RTT_W-1:0] mem_sq;

  assign alpha_c = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign pq_off  = prod_off >>> 16;
  assign pq_rtt  = prod_rtt >>> 16;
  assign count_next = (count != {REQ_W{1'b1}}) ? count + REQ_W'(1) : count;
  assign rem_sh  = {rem[SQ_W-1:0], var_sh[VAR_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign div_sh  = {div_r, quo[SQ_W-1]};
  assign fill_x  = VAR_W'(fill);
  assign mem_sq  = mem_q * mem_q;

  always_comb begin
    logic signed [OFF_W-1:0] d;
    d = $signed({1'b0, cr}) - $signed({1'b0, cs});
    if (d[OFF_W-1]) begin
      rtt_clamp = '0;
    end else if (|d[OFF_W-2:RTT_W]) begin
      rtt_clamp = {RTT_W{1'b1}};
    end else begin
      rtt_clamp = d[RTT_W-1:0];
    end
  end

  always_comb begin
    half   = $signed({{(OFF_W+1-RTT_W){1'b0}}, rtt_r}) - $signed({proc_r[OFF_W-1], proc_r});
    half_d = half >>> 1;
    off_w  = $signed({3'b000, ss}) + $signed({{2{half_d[OFF_W]}}, half_d})
           - $signed({3'b000, cr});
    if (off_w[OFF_W+2:OFF_W-1] != {4{off_w[OFF_W+2]}}) begin
      off_sat = off_w[OFF_W+2] ? {1'b1, {(OFF_W-1){1'b0}}} : {1'b0, {(OFF_W-1){1'b1}}};
    end else begin
      off_sat = off_w[OFF_W-1:0];
    end
  end

  assign sts.is_server = is_server;
  assign sts.fill_nz   = (fill != '0);
  assign sts.rd_last   = (FILL_W'(idx) == fill - FILL_W'(1));

  assign res_accepted = !srv;
  assign res_offset   = off_est;
  assign res_rtt      = rtt_est;
  assign res_jitter   = jit_est;
  assign res_sync     = sync_flag;

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      win_mem[head] <= rtt_r;
    end
    if (cmd.rd) begin
      mem_q <= win_mem[idx];
    end
  end

  // control and estimate state
  always_ff @(posedge clk) begin
    if (rst) begin
      is_server <= 1'b0;
      alpha     <= ALPHA_W'(6554);
      required  <= REQ_W'(8);
      fill      <= '0;
      head      <= '0;
      off_est   <= '0;
      rtt_est   <= '0;
      jit_est   <= '0;
      count     <= '0;
      sync_flag <= 1'b0;
      rd_vld    <= 1'b0;
      srv       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IS_SERVER: is_server <= cfg_data[0];
          CFG_ALPHA:     alpha     <= cfg_data[ALPHA_W-1:0];
          CFG_REQUIRED:  required  <= cfg_data[REQ_W-1:0];
          default:       ;
        endcase
      end
      rd_vld <= cmd.rd;
      if (cmd.latch) begin
        srv <= is_server;
      end
      if (cmd.commit) begin
        head <= (head == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : head + WIN_AW'(1);
        if (fill != FILL_W'(WINDOW_DEPTH)) begin
          fill <= fill + FILL_W'(1);
        end
        if (sync_flag) begin
          off_est <= off_est + pq_off[OFF_W-1:0];
          rtt_est <= rtt_est + pq_rtt[RTT_W-1:0];
        end else begin
          off_est <= off_r;
          rtt_est <= rtt_r;
        end
        count <= count_next;
        if (count_next >= required) begin
          sync_flag <= 1'b1;
        end
      end
      if (cmd.jit_write) begin
        jit_est <= quo[RTT_W-1:0];
      end
    end
  end

  // payload pipeline, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cs <= client_send_time;
      sr <= server_receive_time;
      ss <= server_send_time;
      cr <= client_receive_time;
    end
    if (cmd.prep1) begin
      rtt_r  <= rtt_clamp;
      proc_r <= $signed({1'b0, ss}) - $signed({1'b0, sr});
    end
    if (cmd.prep2) begin
      off_r <= off_sat;
    end
    if (cmd.diff) begin
      diff_off <= $signed({off_r[OFF_W-1], off_r}) - $signed({off_est[OFF_W-1], off_est});
      diff_rtt <= $signed({1'b0, rtt_r}) - $signed({1'b0, rtt_est});
    end
    if (cmd.mul) begin
      prod_off <= diff_off * $signed({1'b0, alpha_c});
      prod_rtt <= diff_rtt * $signed({1'b0, alpha_c});
    end
    if (cmd.commit) begin
      idx <= '0;
      s1  <= '0;
      s2  <= '0;
    end else begin
      if (cmd.rd) begin
        idx <= idx + WIN_AW'(1);
      end
      if (rd_vld) begin
        s1 <= s1 + S1_W'(mem_q);
        s2 <= s2 + S2_W'(mem_sq);
      end
    end
    if (cmd.var_mul) begin
      ns2  <= fill_x * VAR_W'(s2);
      s1sq <= VAR_W'(s1) * VAR_W'(s1);
    end
    // integer square root, one result bit per step
    if (cmd.sqrt_load) begin
      var_sh <= ns2 - s1sq;
      rem    <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      var_sh <= {var_sh[VAR_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQ_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQ_W-2:0], 1'b0};
      end
    end
    // restoring divide of the root by the fill count
    if (cmd.div_load) begin
      quo   <= root;
      div_r <= '0;
    end else if (cmd.div_step) begin
      if (div_sh >= {1'b0, fill}) begin
        div_r <= FILL_W'(div_sh - {1'b0, fill});
        quo   <= {quo[SQ_W-2:0], 1'b1};
      end else begin
        div_r <= div_sh[FILL_W-1:0];
        quo   <= {quo[SQ_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/clock_offset_estimator.sv
// Clock offset estimator, sequenced one item at a time.
// In server mode an item passes straight to the result; with one window entry after the
// update the window statistics are skipped, else the window is summed and the jitter found
// by square root and divide steps, which dominate. A new item waits for the last result.
// Reset (rst, synchronous): estimates, window fill, sample count and sync clear, config
// returns to alpha 6554, 8 required samples, client mode. Needs coe_pkg, coe_ctrl, coe_dp.
`include "clock_offset_estimator_assert.svh"
module clock_offset_estimator
  import coe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TS_W-1:0]       client_send_time,
  input  logic [TS_W-1:0]       server_receive_time,
  input  logic [TS_W-1:0]       server_send_time,
  input  logic [TS_W-1:0]       client_receive_time,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  accepted,
  output logic [OFF_W-1:0]      time_offset,
  output logic [RTT_W-1:0]      round_trip,
  output logic [RTT_W-1:0]      jitter,
  output logic                  synchronized
);

  cmd_t cmd;
  sts_t sts;
  logic emit;
  logic out_busy;
  logic res_accepted, res_sync;
  logic [OFF_W-1:0] res_offset;
  logic [RTT_W-1:0] res_rtt, res_jitter;

  // the result register holds an item until taken; the sequencer waits in
  // its final state only when a previous item is still pending
  assign out_busy = out_valid && !out_ready;

  coe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .sts      (sts),
    .cmd      (cmd),
    .emit     (emit)
  );

  coe_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .client_send_time    (client_send_time),
    .server_receive_time (server_receive_time),
    .server_send_time    (server_send_time),
    .client_receive_time (client_receive_time),
    .cmd                 (cmd),
    .sts                 (sts),
    .res_accepted        (res_accepted),
    .res_offset          (res_offset),
    .res_rtt             (res_rtt),
    .res_jitter          (res_jitter),
    .res_sync            (res_sync)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      accepted     <= res_accepted;
      time_offset  <= res_offset;
      round_trip   <= res_rtt;
      jitter       <= res_jitter;
      synchronized <= res_sync;
    end
  end

  // a new result never lands on one that is still waiting
  `COE_ASSERT_NOW(a_no_overwrite, clk, rst, emit, !out_valid || out_ready)
  // one item in flight: after an accept the input side closes
  `COE_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  // an accept and a result hand-off never share a cycle
  `COE_ASSERT_NOW(a_accept_not_emit, clk, rst, in_valid && in_ready, !emit)

endmodule

// File: dv/clock_offset_estimator_chk.sv
// Checker for the clock offset estimator: mirrors the estimator state,
// predicts each result item and compares it. Depends on coe_pkg.
module clock_offset_estimator_chk
  import coe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TS_W-1:0]       client_send_time,
  input  logic [TS_W-1:0]       server_receive_time,
  input  logic [TS_W-1:0]       server_send_time,
  input  logic [TS_W-1:0]       client_receive_time,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  accepted,
  input  logic [OFF_W-1:0]      time_offset,
  input  logic [RTT_W-1:0]      round_trip,
  input  logic [RTT_W-1:0]      jitter,
  input  logic                  synchronized,
  output int                    errors,
  output int                    pending,
  output int                    results_seen
);

  typedef struct packed {
    logic             acc;
    logic [OFF_W-1:0] off;
    logic [RTT_W-1:0] rtt;
    logic [RTT_W-1:0] jit;
    logic             sync;
  } estimate_t;

  estimate_t estimate_q[$];

  logic             m_server;
  logic [16:0]      m_alpha;
  logic [7:0]       m_required;
  logic [RTT_W-1:0] m_win [WINDOW_DEPTH];
  int               m_fill, m_head;
  longint           m_off, m_rtt;
  logic [RTT_W-1:0] m_jit;
  int               m_count;
  logic             m_sync;

  function automatic longint floor_shift16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_sync(input estimate_t e);
    estimate_q.push_back(e);
  endtask

  task automatic absorb_response();
    longint cs, sr, ss, cr, rtt, half, off, a;
    longint unsigned s1, s2, n;
    estimate_t e;
    cs = longint'(client_send_time);
    sr = longint'(server_receive_time);
    ss = longint'(server_send_time);
    cr = longint'(client_receive_time);
    e.acc = 1'b0;
    if (!m_server) begin
      a = (m_alpha > 17'd65536) ? 65536 : longint'(m_alpha);
      rtt = cr - cs;
      if (rtt < 0) rtt = 0;
      if (rtt > 16777215) rtt = 16777215;
      half = (rtt - (ss - sr)) >>> 1;
      off = ss + half - cr;
      if (off > 64'sd1099511627775) off = 64'sd1099511627775;
      if (off < -64'sd1099511627776) off = -64'sd1099511627776;
      m_win[m_head] = rtt[RTT_W-1:0];
      m_head = (m_head + 1) % WINDOW_DEPTH;
      if (m_fill < WINDOW_DEPTH) m_fill++;
      if (m_fill >= 2) begin
        s1 = 0;
        s2 = 0;
        n = m_fill;
        for (int i = 0; i < m_fill; i++) begin
          s1 += m_win[i];
          s2 += longint'(m_win[i]) * longint'(m_win[i]);
        end
        m_jit = RTT_W'(root_floor(n * s2 - s1 * s1) / n);
      end
      if (!m_sync) begin
        m_off = off;
        m_rtt = rtt;
      end else begin
        m_off = m_off + floor_shift16((off - m_off) * a);
        m_rtt = m_rtt + floor_shift16((rtt - m_rtt) * a);
      end
      if (m_count < 255) m_count++;
      if (m_count >= m_required) m_sync = 1'b1;
      e.acc = 1'b1;
    end
    e.off = OFF_W'(m_off);
    e.rtt = RTT_W'(m_rtt);
    e.jit = m_jit;
    e.sync = m_sync;
    predict_sync(e);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    estimate_t w;
    if (rst) begin
      m_server <= 0; m_alpha <= 17'd6554; m_required <= 8'd8;
      m_fill <= 0; m_head <= 0; m_off <= 0; m_rtt <= 0;
      m_jit <= '0; m_count <= 0; m_sync <= 0;
      estimate_q.delete();
      errors <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IS_SERVER: m_server = cfg_data[0];
          CFG_ALPHA:     m_alpha = cfg_data[16:0];
          CFG_REQUIRED:  m_required = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_response();
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          w = estimate_q.pop_front();
          if (accepted !== w.acc) report_mismatch("accepted", accepted, w.acc);
          if (time_offset !== w.off) report_mismatch("time_offset", time_offset, w.off);
          if (round_trip !== w.rtt) report_mismatch("round_trip", round_trip, w.rtt);
          if (jitter !== w.jit) report_mismatch("jitter", jitter, w.jit);
          if (synchronized !== w.sync)
            report_mismatch("synchronized", synchronized, w.sync);
        end
      end
      pending <= estimate_q.size();
    end
  end

endmodule

// File: dv/tb_clock_offset_estimator.sv
// Testbench top for the clock offset estimator: clock, reset, register
// phases and response stimulus. Depends on coe_pkg and the checker module.
module tb_clock_offset_estimator;
  import coe_pkg::*;

  logic                  clk, rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid, in_ready;
  logic [TS_W-1:0]       cst, srt, sst, crt;
  logic                  out_valid, out_ready;
  logic                  accepted, synchronized;
  logic [OFF_W-1:0]      time_offset;
  logic [RTT_W-1:0]      round_trip, jitter;
  int                    errors, pending, results_seen;
  bit                    calm;   // no idling on either side

  clock_offset_estimator u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .client_send_time(cst), .server_receive_time(srt),
    .server_send_time(sst), .client_receive_time(crt),
    .out_valid, .out_ready, .accepted, .time_offset, .round_trip, .jitter,
    .synchronized
  );

  clock_offset_estimator_chk u_chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .client_send_time(cst), .server_receive_time(srt),
    .server_send_time(sst), .client_receive_time(crt),
    .out_valid, .out_ready, .accepted, .time_offset, .round_trip, .jitter,
    .synchronized, .errors, .pending, .results_seen
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls in random bursts, off during the calm tail.
  initial begin
    int n;
    out_ready = 0;
    forever begin
      out_ready <= 1;
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [TS_W-1:0] rand_ts();
    return {8'($urandom), 32'($urandom)};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Wait until every expected result is back, plus the block's tail latency.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Offer one response; hold valid with a stable payload until accepted.
  // Valid stays up after the accept until the next offer, an idle burst or a drain.
  task automatic send(input logic [TS_W-1:0] a, b, c, d);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    cst <= a; srt <= b; sst <= c; crt <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Plausible exchange: send time, rtt of varied size, server time about offset away.
  task automatic send_exchange();
    logic [TS_W-1:0] base, rtt, proc, offs;
    base = rand_ts();
    case ($urandom_range(0, 3))
      0: rtt = 40'($urandom_range(0, 2000));
      1: rtt = 40'($urandom_range(0, 200000));
      2: rtt = {16'd0, 8'($urandom), 16'($urandom)};
      default: rtt = {14'd0, 26'($urandom)};  // may exceed clamp
    endcase
    proc = $urandom_range(0, 3) == 0 ? rand_ts() : 40'($urandom_range(0, 500));
    offs = $urandom_range(0, 3) == 0 ? rand_ts() : 40'($urandom_range(0, 1 << 20));
    send(base, base + offs, base + offs + proc, base + rtt);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send(rand_ts(), rand_ts(), rand_ts(), rand_ts());
      else send_exchange();
    end
  endtask

  localparam logic [TS_W-1:0] TMAX = '1;

  initial begin
    rst = 1; calm = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; cst = '0; srt = '0; sst = '0; crt = '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, extremes and clamps.
    send('0, '0, '0, '0);
    send(TMAX, '0, '0, '0);                    // negative rtt
    send('0, '0, '0, TMAX);                    // rtt clamp
    send('0, '0, TMAX, '0);                    // huge processing time
    send('0, TMAX, '0, 40'd100);               // huge negative processing time
    send(40'd5, 40'd7, 40'd9, 40'd12);         // odd halving
    send(40'd5, 40'd7, 40'd10, 40'd12);
    send(TMAX, TMAX, TMAX, TMAX);
    send(40'h5555555555, 40'hAAAAAAAAAA, 40'h5555555555, 40'hAAAAAAAAAA);
    send(40'hAAAAAAAAAA, 40'h5555555555, 40'hAAAAAAAAAA, 40'h5555555555);
    random_phase(10);
    drain();

    // Server mode: nothing updates.
    write_reg(CFG_IS_SERVER, 1);
    send(40'd1, 40'd2, 40'd3, 40'd4);
    send(TMAX, '0, TMAX, '0);
    drain();
    write_reg(CFG_IS_SERVER, 0);
    // Alpha above one, required samples at zero (first response syncs).
    write_reg(CFG_ALPHA, 131071);
    write_reg(CFG_REQUIRED, 0);
    random_phase(200);
    drain();
    write_reg(CFG_ALPHA, 0);
    write_reg(CFG_REQUIRED, 255);
    random_phase(250);
    // Sender holds off until every expected result is back.
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    random_phase(50);
    drain();
    write_reg(CFG_ALPHA, 65536);
    write_reg(CFG_REQUIRED, 1);
    random_phase(250);
    drain();
    write_reg(CFG_ALPHA, 1);
    write_reg(CFG_IS_SERVER, 1);
    random_phase(40);
    drain();
    write_reg(CFG_IS_SERVER, 0);
    write_reg(CFG_ALPHA, $urandom_range(0, 65536));
    write_reg(CFG_REQUIRED, $urandom_range(1, 255));
    random_phase(300);
    drain();
    write_reg(CFG_ALPHA, 65535);
    write_reg(CFG_REQUIRED, 128);
    random_phase(200);
    calm = 1;
    random_phase(120);
    drain();

    $display("Covered register extremes, server mode, clamps and %0d result items.",
             results_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
